// ===== rtl/vmap_pkg.sv =====
package vmap_pkg;

    localparam int KEY_LEN = 6;
    localparam int MATCH_W = 3;

    localparam logic [7:0] KEYWORD [KEY_LEN] = '{8'h76, 8'h69, 8'h64, 8'h65, 8'h6F, 8'h3D};

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_F  = 8'h46;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_LO_F  = 8'h66;
    localparam logic [7:0] CH_X     = 8'h78;
    localparam logic [7:0] CH_V     = 8'h76;
    localparam logic [7:0] CH_AT    = 8'h40;
    localparam logic [7:0] CH_COMMA = 8'h2C;

    localparam logic [7:0] BPP_16 = 8'd16;
    localparam logic [7:0] BPP_24 = 8'd24;
    localparam logic [7:0] BPP_32 = 8'd32;

    localparam int MID_DEPTH = 2;
    localparam int OUT_DEPTH = 4;
    localparam int OUT_CW    = $clog2(OUT_DEPTH + 1);

    typedef enum logic [3:0] {
        PH_SEARCH,
        PH_WIDTH,
        PH_HEIGHT,
        PH_BPP,
        PH_AT_ZERO,
        PH_AT_X,
        PH_ADDR,
        PH_PITCH,
        PH_DONE,
        PH_FAILED
    } t_phase;

    typedef enum logic [2:0] {
        ST_OK,
        ST_NOT_FOUND,
        ST_BAD_SEP,
        ST_ZERO_WIDTH,
        ST_ZERO_HEIGHT,
        ST_BAD_BPP,
        ST_BAD_PITCH,
        ST_MISALIGNED
    } t_status;

    // Outcome of the parse itself, before the value checks.
    typedef struct packed {
        logic    failed;
        t_status code;
    } t_pre;

    localparam int PRE_W  = $bits(t_pre);
    localparam int RES_W  = 3 + 16 + 16 + 8 + 16 + 32 + 1;

endpackage

// ===== rtl/vmap_fifo.sv =====
module vmap_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_push,
    input  logic [WIDTH-1:0]               i_data,
    input  logic                           i_pop,
    output logic [WIDTH-1:0]               o_data,
    output logic                           o_full,
    output logic                           o_empty,
    output logic [$clog2(DEPTH+1)-1:0]     o_count
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr, n_wr;
    logic [AW-1:0]    r_rd, n_rd;
    logic [CW-1:0]    r_count, n_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_count = r_count;
    assign o_data  = r_mem[r_rd];

    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (do_push) begin
            n_wr = (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (do_pop) begin
            n_rd = (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

// ===== rtl/vmap_front.sv =====
module vmap_front
    import vmap_pkg::*;
#(
    parameter int ADDR_WIDTH = 32,
    parameter int DIM_WIDTH  = 16
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        i_valid,
    input  logic [7:0]                                  i_char_in,
    input  logic                                        i_last,
    output logic                                        o_push,
    output logic [PRE_W+3*DIM_WIDTH+8+ADDR_WIDTH-1:0]   o_job
);

    localparam logic [DIM_WIDTH-1:0] DIM_MAX = '1;

    t_phase               r_phase, n_phase;
    logic [MATCH_W-1:0]   r_match, n_match;
    t_status              r_fail, n_fail;
    logic [DIM_WIDTH-1:0] r_width, n_width;
    logic [DIM_WIDTH-1:0] r_height, n_height;
    logic [7:0]           r_bpp, n_bpp;
    logic [DIM_WIDTH-1:0] r_pitch, n_pitch;
    logic [ADDR_WIDTH-1:0] r_addr, n_addr;
    t_pre                 pre;

    logic       is_dec;
    logic       is_up;
    logic       is_lo;
    logic [3:0] dec_val;
    logic [3:0] nib;
    logic [7:0] key_char;

    function automatic logic [DIM_WIDTH-1:0] dec_dim(input logic [DIM_WIDTH-1:0] acc,
                                                     input logic [3:0] d);
        logic [DIM_WIDTH+3:0] v;
        v = {acc, 3'b000} + {2'b00, acc, 1'b0} + (DIM_WIDTH+4)'(d);
        return (v > (DIM_WIDTH+4)'(DIM_MAX)) ? DIM_MAX : v[DIM_WIDTH-1:0];
    endfunction

    function automatic logic [7:0] dec_bpp(input logic [7:0] acc, input logic [3:0] d);
        logic [11:0] v;
        v = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + 12'(d);
        return (v > 12'd255) ? 8'd255 : v[7:0];
    endfunction

    assign is_dec   = (i_char_in >= CH_ZERO) && (i_char_in <= CH_NINE);
    assign is_up    = (i_char_in >= CH_UP_A) && (i_char_in <= CH_UP_F);
    assign is_lo    = (i_char_in >= CH_LO_A) && (i_char_in <= CH_LO_F);
    assign dec_val  = 4'(i_char_in - CH_ZERO);
    assign key_char = (r_match < MATCH_W'(KEY_LEN)) ? KEYWORD[r_match] : KEYWORD[0];

    always_comb begin
        nib = dec_val;
        if (is_up) begin
            nib = 4'(i_char_in - CH_UP_A + 8'd10);
        end else if (is_lo) begin
            nib = 4'(i_char_in - CH_LO_A + 8'd10);
        end
    end

    always_comb begin
        n_phase  = r_phase;
        n_match  = r_match;
        n_fail   = r_fail;
        n_width  = r_width;
        n_height = r_height;
        n_bpp    = r_bpp;
        n_pitch  = r_pitch;
        n_addr   = r_addr;
        case (r_phase)
            PH_SEARCH: begin
                if (i_char_in == CH_NUL) begin
                    n_fail  = ST_NOT_FOUND;
                    n_phase = PH_FAILED;
                end else if (i_char_in == key_char) begin
                    if (r_match == MATCH_W'(KEY_LEN - 1)) begin
                        n_match = '0;
                        n_phase = PH_WIDTH;
                    end else begin
                        n_match = r_match + 1'b1;
                    end
                end else begin
                    // A broken match may restart on this same byte.
                    n_match = (i_char_in == CH_V) ? MATCH_W'(1) : '0;
                end
            end
            PH_WIDTH: begin
                if (is_dec) begin
                    n_width = dec_dim(r_width, dec_val);
                end else if (i_char_in == CH_X) begin
                    n_phase = PH_HEIGHT;
                end else begin
                    n_fail  = ST_BAD_SEP;
                    n_phase = PH_FAILED;
                end
            end
            PH_HEIGHT: begin
                if (is_dec) begin
                    n_height = dec_dim(r_height, dec_val);
                end else if (i_char_in == CH_X) begin
                    n_phase = PH_BPP;
                end else begin
                    n_fail  = ST_BAD_SEP;
                    n_phase = PH_FAILED;
                end
            end
            PH_BPP: begin
                if (is_dec) begin
                    n_bpp = dec_bpp(r_bpp, dec_val);
                end else if (i_char_in == CH_AT) begin
                    n_phase = PH_AT_ZERO;
                end else begin
                    n_fail  = ST_BAD_SEP;
                    n_phase = PH_FAILED;
                end
            end
            PH_AT_ZERO: begin
                if (i_char_in == CH_ZERO) begin
                    n_phase = PH_AT_X;
                end else begin
                    n_fail  = ST_BAD_SEP;
                    n_phase = PH_FAILED;
                end
            end
            PH_AT_X: begin
                if (i_char_in == CH_X) begin
                    n_phase = PH_ADDR;
                end else begin
                    n_fail  = ST_BAD_SEP;
                    n_phase = PH_FAILED;
                end
            end
            PH_ADDR: begin
                if (is_dec || is_up || is_lo) begin
                    n_addr = {r_addr[ADDR_WIDTH-5:0], nib};
                end else if (i_char_in == CH_COMMA) begin
                    n_phase = PH_PITCH;
                end else begin
                    n_fail  = ST_BAD_SEP;
                    n_phase = PH_FAILED;
                end
            end
            PH_PITCH: begin
                if (is_dec) begin
                    n_pitch = dec_dim(r_pitch, dec_val);
                end else begin
                    n_phase = PH_DONE;
                end
            end
            PH_DONE: begin
            end
            PH_FAILED: begin
            end
            default: begin
                n_phase = PH_FAILED;
            end
        endcase
    end

    // The end of the line acts like one more byte that matches nothing.
    always_comb begin
        pre.failed = 1'b1;
        pre.code   = ST_BAD_SEP;
        case (n_phase)
            PH_FAILED: begin
                pre.code = n_fail;
            end
            PH_SEARCH: begin
                pre.code = ST_NOT_FOUND;
            end
            PH_PITCH, PH_DONE: begin
                pre.failed = 1'b0;
                pre.code   = ST_OK;
            end
            default: begin
                pre.code = ST_BAD_SEP;
            end
        endcase
    end

    assign o_push = i_valid && i_last;
    assign o_job  = {pre, n_width, n_height, n_bpp, n_pitch, n_addr};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && i_last)) begin
            r_phase  <= PH_SEARCH;
            r_match  <= '0;
            r_fail   <= ST_OK;
            r_width  <= '0;
            r_height <= '0;
            r_bpp    <= '0;
            r_pitch  <= '0;
            r_addr   <= '0;
        end else if (i_valid) begin
            r_phase  <= n_phase;
            r_match  <= n_match;
            r_fail   <= n_fail;
            r_width  <= n_width;
            r_height <= n_height;
            r_bpp    <= n_bpp;
            r_pitch  <= n_pitch;
            r_addr   <= n_addr;
        end
    end

endmodule

// ===== rtl/vmap_back.sv =====
module vmap_back
    import vmap_pkg::*;
#(
    parameter int PAGE_BITS  = 12,
    parameter int ADDR_WIDTH = 32,
    parameter int DIM_WIDTH  = 16
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        i_job_empty,
    input  logic [PRE_W+3*DIM_WIDTH+8+ADDR_WIDTH-1:0]   i_job,
    output logic                                        o_job_pop,
    input  logic                                        i_pop,
    output logic                                        o_empty,
    output logic [2:0]                                  o_status,
    output logic [15:0]                                 o_width_px,
    output logic [15:0]                                 o_height_px,
    output logic [7:0]                                  o_bits_per_pixel,
    output logic [15:0]                                 o_line_pitch,
    output logic [31:0]                                 o_base_address,
    output logic                                        o_rgb_layout
);

    localparam int PROD_W = DIM_WIDTH + 8;
    localparam logic [ADDR_WIDTH-1:0] PAGE_MASK = ADDR_WIDTH'((65'd1 << PAGE_BITS) - 65'd1);

    t_pre                  q_pre;
    logic [DIM_WIDTH-1:0]  q_width, q_height, q_pitch;
    logic [7:0]            q_bpp;
    logic [ADDR_WIDTH-1:0] q_addr;

    logic                  r_s1_valid;
    t_pre                  r_s1_pre;
    logic [DIM_WIDTH-1:0]  r_s1_width, r_s1_height, r_s1_pitch;
    logic [7:0]            r_s1_bpp;
    logic [ADDR_WIDTH-1:0] r_s1_addr;
    logic [PROD_W-1:0]     r_s1_prod;

    t_status               status;
    logic [RES_W-1:0]      res;
    logic [RES_W-1:0]      head;
    logic [OUT_CW-1:0]     out_count;
    logic                  out_full;

    assign {q_pre, q_width, q_height, q_bpp, q_pitch, q_addr} = i_job;

    // A job leaves the queue only when the result queue has a slot for it,
    // so the multiply stage never has to stall.
    assign o_job_pop = !i_job_empty
                       && ((OUT_CW+1)'(out_count) + (OUT_CW+1)'(r_s1_valid)
                           < (OUT_CW+1)'(OUT_DEPTH));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= o_job_pop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_job_pop) begin
            r_s1_pre    <= q_pre;
            r_s1_width  <= q_width;
            r_s1_height <= q_height;
            r_s1_bpp    <= q_bpp;
            r_s1_pitch  <= q_pitch;
            r_s1_addr   <= q_addr;
            r_s1_prod   <= PROD_W'(q_width) * PROD_W'(q_bpp);
        end
    end

    always_comb begin
        if (r_s1_pre.failed) begin
            status = r_s1_pre.code;
        end else if (r_s1_width == '0) begin
            status = ST_ZERO_WIDTH;
        end else if (r_s1_height == '0) begin
            status = ST_ZERO_HEIGHT;
        end else if (r_s1_bpp != BPP_16 && r_s1_bpp != BPP_24 && r_s1_bpp != BPP_32) begin
            status = ST_BAD_BPP;
        end else if (PROD_W'(r_s1_pitch) < (r_s1_prod >> 3)) begin
            status = ST_BAD_PITCH;
        end else if ((r_s1_addr & PAGE_MASK) != '0) begin
            status = ST_MISALIGNED;
        end else begin
            status = ST_OK;
        end
    end

    always_comb begin
        if (status == ST_OK) begin
            res = {status, 16'(r_s1_width), 16'(r_s1_height), r_s1_bpp,
                   16'(r_s1_pitch), 32'(r_s1_addr), (r_s1_bpp != BPP_16)};
        end else begin
            res = {status, {(RES_W-3){1'b0}}};
        end
    end

    vmap_fifo #(
        .WIDTH (RES_W),
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_s1_valid),
        .i_data  (res),
        .i_pop   (i_pop),
        .o_data  (head),
        .o_full  (out_full),
        .o_empty (o_empty),
        .o_count (out_count)
    );

    assign {o_status, o_width_px, o_height_px, o_bits_per_pixel, o_line_pitch,
            o_base_address, o_rgb_layout} = out_full ? head : head;

endmodule

// ===== rtl/video_mode_argument_parser.sv =====
// Streaming parser for a "video=WxHxBPP@0xADDR,PITCH" argument. Bytes of a command
// line are pushed one per clock while full is low; the beat marked last ends the line and
// yields one result: a status code, and on success the width, height, bpp, pitch, base
// address and RGB layout (all other fields read zero when status is not OK). The parser
// takes a byte every cycle that full is low; a result passes through the job queue, the
// width-times-bpp multiply stage used for the pitch check and the result queue before
// it shows on the output ports. Full rises only when the multiply stage and the result
// queue together hold four results and two more finished lines are queued behind them.
module video_mode_argument_parser
    import vmap_pkg::*;
#(
    parameter int PAGE_BITS  = 12,
    parameter int ADDR_WIDTH = 32,
    parameter int DIM_WIDTH  = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    output logic        o_full,
    input  logic [7:0]  i_char_in,
    input  logic        i_last,
    output logic        o_empty,
    input  logic        i_pop,
    output logic [2:0]  o_status,
    output logic [15:0] o_width_px,
    output logic [15:0] o_height_px,
    output logic [7:0]  o_bits_per_pixel,
    output logic [15:0] o_line_pitch,
    output logic [31:0] o_base_address,
    output logic        o_rgb_layout
);

    localparam int JOB_W = PRE_W + 3 * DIM_WIDTH + 8 + ADDR_WIDTH;

    logic                           in_beat;
    logic                           job_push;
    logic [JOB_W-1:0]               job_in;
    logic [JOB_W-1:0]               job_out;
    logic                           job_empty;
    logic                           job_pop;
    logic [$clog2(MID_DEPTH+1)-1:0] job_count;

    assign in_beat = i_push && !o_full;

    vmap_front #(
        .ADDR_WIDTH (ADDR_WIDTH),
        .DIM_WIDTH  (DIM_WIDTH)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (in_beat),
        .i_char_in (i_char_in),
        .i_last    (i_last),
        .o_push    (job_push),
        .o_job     (job_in)
    );

    vmap_fifo #(
        .WIDTH (JOB_W),
        .DEPTH (MID_DEPTH)
    ) u_job_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_data  (job_in),
        .i_pop   (job_pop),
        .o_data  (job_out),
        .o_full  (o_full),
        .o_empty (job_empty),
        .o_count (job_count)
    );

    vmap_back #(
        .PAGE_BITS  (PAGE_BITS),
        .ADDR_WIDTH (ADDR_WIDTH),
        .DIM_WIDTH  (DIM_WIDTH)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_job_empty      (job_empty || (job_count == '0)),
        .i_job            (job_out),
        .o_job_pop        (job_pop),
        .i_pop            (i_pop),
        .o_empty          (o_empty),
        .o_status         (o_status),
        .o_width_px       (o_width_px),
        .o_height_px      (o_height_px),
        .o_bits_per_pixel (o_bits_per_pixel),
        .o_line_pitch     (o_line_pitch),
        .o_base_address   (o_base_address),
        .o_rgb_layout     (o_rgb_layout)
    );

endmodule

// ===== dv/tb_video_mode_argument_parser.sv =====
module tb_video_mode_argument_parser;
    timeunit 1ns;
    timeprecision 1ps;

    import vmap_pkg::*;

    localparam int              PAGE_BITS    = 12;
    localparam longint unsigned DIM_MAX      = 65535;
    localparam longint unsigned BPP_MAX      = 255;
    localparam int              N_DIR        = 25;
    localparam int              MIN_BEATS    = 1500;
    localparam int              MIN_LINES    = 24;
    localparam int              HOLD_CYCLES  = 400;
    localparam int              DRAIN_CYCLES = 24;
    localparam int              TIMEOUT_NS   = 3_000_000;

    typedef struct packed {
        t_status     status;
        logic [15:0] width;
        logic [15:0] height;
        logic [7:0]  bpp;
        logic [15:0] pitch;
        logic [31:0] addr;
        logic        rgb;
    } t_mode_result;

    typedef struct {
        string        text;
        int           nul_pos;
        bit           has_exp;
        t_mode_result exp;
    } t_dir_row;

    logic        i_clk     = 1'b0;
    logic        i_rst_n   = 1'b0;
    logic        i_push    = 1'b0;
    logic [7:0]  i_char_in = 8'h00;
    logic        i_last    = 1'b0;
    logic        i_pop     = 1'b0;
    logic        o_full;
    logic        o_empty;
    logic [2:0]  o_status;
    logic [15:0] o_width_px;
    logic [15:0] o_height_px;
    logic [7:0]  o_bits_per_pixel;
    logic [15:0] o_line_pitch;
    logic [31:0] o_base_address;
    logic        o_rgb_layout;

    // Parser state mirrored by the predictor.
    t_phase          prs_phase;
    t_status         prs_fail;
    int unsigned     kw_idx;
    longint unsigned acc_w;
    longint unsigned acc_h;
    longint unsigned acc_bpp;
    longint unsigned acc_pitch;
    logic [31:0]     acc_addr;

    t_mode_result exp_modes[$];
    logic [7:0]   line_bytes[$];
    t_dir_row     dir_rows[N_DIR];

    int       send_idle_pct  = 0;
    int       recv_stall_pct = 0;
    bit       hold_req       = 1'b0;
    int       n_errors       = 0;
    int       n_beats        = 0;
    int       n_lines        = 0;
    int       n_rand         = 0;
    int       n_checked      = 0;
    int       n_ok           = 0;
    bit [7:0] status_seen    = '0;

    video_mode_argument_parser u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_push           (i_push),
        .o_full           (o_full),
        .i_char_in        (i_char_in),
        .i_last           (i_last),
        .o_empty          (o_empty),
        .i_pop            (i_pop),
        .o_status         (o_status),
        .o_width_px       (o_width_px),
        .o_height_px      (o_height_px),
        .o_bits_per_pixel (o_bits_per_pixel),
        .o_line_pitch     (o_line_pitch),
        .o_base_address   (o_base_address),
        .o_rgb_layout     (o_rgb_layout)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic void clear_parser();
        prs_phase = PH_SEARCH;
        prs_fail  = ST_OK;
        kw_idx    = 0;
        acc_w     = 0;
        acc_h     = 0;
        acc_bpp   = 0;
        acc_pitch = 0;
        acc_addr  = '0;
    endfunction

    function automatic bit is_digit(logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function automatic longint unsigned dec_shift(longint unsigned acc, logic [7:0] c,
                                                  longint unsigned cap);
        longint unsigned v;
        v = acc * 10 + longint'(c - CH_ZERO);
        return (v > cap) ? cap : v;
    endfunction

    function automatic void fail_parse(t_status code);
        prs_fail  = code;
        prs_phase = PH_FAILED;
    endfunction

    function automatic void parse_char(logic [7:0] c);
        case (prs_phase)
            PH_SEARCH: begin
                if (c == CH_NUL) begin
                    fail_parse(ST_NOT_FOUND);
                end else if (c == KEYWORD[kw_idx]) begin
                    kw_idx++;
                    if (kw_idx == KEY_LEN) begin
                        kw_idx    = 0;
                        prs_phase = PH_WIDTH;
                    end
                end else begin
                    // A broken match may itself be the start of a new one.
                    kw_idx = (c == CH_V) ? 1 : 0;
                end
            end
            PH_WIDTH: begin
                if (is_digit(c)) acc_w = dec_shift(acc_w, c, DIM_MAX);
                else if (c == CH_X) prs_phase = PH_HEIGHT;
                else fail_parse(ST_BAD_SEP);
            end
            PH_HEIGHT: begin
                if (is_digit(c)) acc_h = dec_shift(acc_h, c, DIM_MAX);
                else if (c == CH_X) prs_phase = PH_BPP;
                else fail_parse(ST_BAD_SEP);
            end
            PH_BPP: begin
                if (is_digit(c)) acc_bpp = dec_shift(acc_bpp, c, BPP_MAX);
                else if (c == CH_AT) prs_phase = PH_AT_ZERO;
                else fail_parse(ST_BAD_SEP);
            end
            PH_AT_ZERO: begin
                if (c == CH_ZERO) prs_phase = PH_AT_X;
                else fail_parse(ST_BAD_SEP);
            end
            PH_AT_X: begin
                if (c == CH_X) prs_phase = PH_ADDR;
                else fail_parse(ST_BAD_SEP);
            end
            PH_ADDR: begin
                if (is_digit(c)) begin
                    acc_addr = {acc_addr[27:0], 4'(c - CH_ZERO)};
                end else if (c >= CH_UP_A && c <= CH_UP_F) begin
                    acc_addr = {acc_addr[27:0], 4'(c - CH_UP_A + 8'd10)};
                end else if (c >= CH_LO_A && c <= CH_LO_F) begin
                    acc_addr = {acc_addr[27:0], 4'(c - CH_LO_A + 8'd10)};
                end else if (c == CH_COMMA) begin
                    prs_phase = PH_PITCH;
                end else begin
                    fail_parse(ST_BAD_SEP);
                end
            end
            PH_PITCH: begin
                if (is_digit(c)) acc_pitch = dec_shift(acc_pitch, c, DIM_MAX);
                else prs_phase = PH_DONE;
            end
            PH_DONE: ;
            default: prs_phase = PH_FAILED;
        endcase
    endfunction

    // Advances the predictor by one byte; returns 1 with the mode result on a last byte.
    function automatic bit parse_beat(logic [7:0] c, logic l, output t_mode_result r);
        t_status st;
        r = '0;
        parse_char(c);
        if (!l) return 1'b0;
        if (prs_phase != PH_DONE && prs_phase != PH_FAILED) parse_char(CH_NUL);
        if (prs_phase == PH_FAILED) st = prs_fail;
        else if (acc_w == 0) st = ST_ZERO_WIDTH;
        else if (acc_h == 0) st = ST_ZERO_HEIGHT;
        else if (acc_bpp != BPP_16 && acc_bpp != BPP_24 && acc_bpp != BPP_32) st = ST_BAD_BPP;
        else if (acc_pitch < (acc_w * acc_bpp) / 8) st = ST_BAD_PITCH;
        else if ((acc_addr & ((32'd1 << PAGE_BITS) - 1)) != 0) st = ST_MISALIGNED;
        else st = ST_OK;
        r.status = st;
        if (st == ST_OK) begin
            r.width  = acc_w[15:0];
            r.height = acc_h[15:0];
            r.bpp    = acc_bpp[7:0];
            r.pitch  = acc_pitch[15:0];
            r.addr   = acc_addr;
            r.rgb    = (acc_bpp != BPP_16);
        end
        clear_parser();
        return 1'b1;
    endfunction

    function automatic void add_text(string s);
        foreach (s[i]) line_bytes.push_back(s[i]);
    endfunction

    function automatic longint unsigned pick_dim();
        case ($urandom_range(9))
            0:       return 0;
            1:       return $urandom_range(999999, 65000);
            default: return $urandom_range(4096, 1);
        endcase
    endfunction

    task automatic build_random_line();
        longint unsigned w;
        longint unsigned h;
        longint unsigned bpp;
        longint unsigned pitch;
        longint unsigned need;
        logic [31:0]     addr;
        string           hx;
        int              pos;
        line_bytes.delete();
        if ($urandom_range(99) < 12) begin
            repeat ($urandom_range(20, 1)) line_bytes.push_back(8'($urandom_range(255)));
            return;
        end
        case ($urandom_range(3))
            0: ;
            1: add_text("vid");
            2: add_text("vvideo");
            default: begin
                repeat ($urandom_range(6, 1)) line_bytes.push_back(8'($urandom_range(126, 32)));
            end
        endcase
        w = pick_dim();
        h = pick_dim();
        case ($urandom_range(9))
            0:       bpp = $urandom_range(400);
            1, 2, 3: bpp = 16;
            4, 5, 6: bpp = 24;
            default: bpp = 32;
        endcase
        add_text("video=");
        add_text(($urandom_range(4) == 0) ? $sformatf("%05d", w) : $sformatf("%0d", w));
        add_text("x");
        add_text($sformatf("%0d", h));
        add_text("x");
        add_text($sformatf("%0d", bpp));
        add_text("@0x");
        addr = $urandom;
        if ($urandom_range(7) != 0) addr[11:0] = '0;
        hx = $sformatf("%0h", addr);
        // Extra leading digits make the address wrap.
        if ($urandom_range(5) == 0) hx = {$sformatf("%0h", $urandom_range(255)), hx};
        foreach (hx[i]) begin
            if (hx[i] >= CH_LO_A && $urandom_range(1) == 1) line_bytes.push_back(8'(hx[i] - 8'h20));
            else line_bytes.push_back(hx[i]);
        end
        need = ((w > DIM_MAX ? DIM_MAX : w) * (bpp > BPP_MAX ? BPP_MAX : bpp)) / 8;
        case ($urandom_range(9))
            0:       pitch = (need > 0) ? need - 1 : 0;
            1:       pitch = $urandom_range(99999);
            default: pitch = need + $urandom_range(64);
        endcase
        add_text(",");
        add_text($sformatf("%0d", pitch));
        case ($urandom_range(5))
            0: begin
                line_bytes.push_back(CH_NUL);
                add_text("quiet");
            end
            1:       add_text(" console=ttyS0");
            default: ;
        endcase
        pos = $urandom_range(line_bytes.size() - 1);
        case ($urandom_range(9))
            0: line_bytes[pos] = 8'($urandom_range(255));
            1: while (line_bytes.size() > pos + 1) void'(line_bytes.pop_back());
            default: ;
        endcase
    endtask

    task automatic send_beat(logic [7:0] c, logic l, bit has_exp, t_mode_result typed);
        t_mode_result pred;
        while ($urandom_range(99) < send_idle_pct) begin
            i_push <= 1'b0;
            @(posedge i_clk);
        end
        i_push    <= 1'b1;
        i_char_in <= c;
        i_last    <= l;
        @(posedge i_clk);
        while (o_full) @(posedge i_clk);
        n_beats++;
        if (parse_beat(c, l, pred)) exp_modes.push_back(has_exp ? typed : pred);
    endtask

    task automatic send_line(bit has_exp, t_mode_result typed);
        foreach (line_bytes[i]) begin
            send_beat(line_bytes[i], i == line_bytes.size() - 1, has_exp, typed);
        end
        n_lines++;
    endtask

    task automatic check_mode();
        t_mode_result    want;
        longint unsigned got_v[7];
        longint unsigned want_v[7];
        string           names[7];
        names = '{"status", "width_px", "height_px", "bits_per_pixel", "line_pitch",
                  "base_address", "rgb_layout"};
        got_v = '{o_status, o_width_px, o_height_px, o_bits_per_pixel, o_line_pitch,
                  o_base_address, o_rgb_layout};
        if (exp_modes.size() == 0) begin
            $display("%0t: result beat with nothing expected, status %0d", $time, o_status);
            n_errors++;
            return;
        end
        want   = exp_modes.pop_front();
        want_v = '{want.status, want.width, want.height, want.bpp, want.pitch, want.addr,
                   want.rgb};
        foreach (names[k]) begin
            if (got_v[k] != want_v[k]) begin
                $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h",
                         $time, names[k], want_v[k], got_v[k]);
                n_errors++;
            end
        end
        n_checked++;
        status_seen[want.status] = 1'b1;
        if (want.status == ST_OK) n_ok++;
    endtask

    // Result side.
    initial begin
        wait (i_rst_n === 1'b1);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                i_pop <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            i_pop <= ($urandom_range(99) >= recv_stall_pct);
            @(posedge i_clk);
            if (i_pop && !o_empty) check_mode();
        end
    end

    initial begin
        #TIMEOUT_NS;
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        dir_rows = '{
            '{"a",                       -1, 1'b1, '{status: ST_NOT_FOUND, default: '0}},
            '{"vide",                    -1, 1'b1, '{status: ST_NOT_FOUND, default: '0}},
            '{"xvideo=1x1x16@0x0,2",      1, 1'b1, '{status: ST_NOT_FOUND, default: '0}},
            '{"video=",                  -1, 1'b1, '{status: ST_BAD_SEP, default: '0}},
            '{"video=1x1x16",            -1, 1'b1, '{status: ST_BAD_SEP, default: '0}},
            '{"video=1X1x16@0x0,2",      -1, 1'b1, '{status: ST_BAD_SEP, default: '0}},
            '{"video=1x1x16@1",          -1, 1'b1, '{status: ST_BAD_SEP, default: '0}},
            '{"video=1x1x16@0y",         -1, 1'b1, '{status: ST_BAD_SEP, default: '0}},
            '{"video=1x1x16@0x0g,2",     -1, 1'b1, '{status: ST_BAD_SEP, default: '0}},
            '{"video=2x2x16@0x10",       -1, 1'b1, '{status: ST_BAD_SEP, default: '0}},
            '{"video=0x1x16@0x0,2",      -1, 1'b1, '{status: ST_ZERO_WIDTH, default: '0}},
            '{"video=x1x16@0x0,2",       -1, 1'b1, '{status: ST_ZERO_WIDTH, default: '0}},
            '{"video=1x0x16@0x0,2",      -1, 1'b1, '{status: ST_ZERO_HEIGHT, default: '0}},
            '{"video=1x1x15@0x0,2",      -1, 1'b1, '{status: ST_BAD_BPP, default: '0}},
            '{"video=1x1x999@0x0,9",     -1, 1'b1, '{status: ST_BAD_BPP, default: '0}},
            '{"video=100x1x24@0x0,299",  -1, 1'b1, '{status: ST_BAD_PITCH, default: '0}},
            '{"video=1x1x16@0x0,",       -1, 1'b1, '{status: ST_BAD_PITCH, default: '0}},
            '{"video=70000x1x32@0x0,99999", -1, 1'b1, '{status: ST_BAD_PITCH, default: '0}},
            '{"video=1x1x16@0xFFF,2",    -1, 1'b1, '{status: ST_MISALIGNED, default: '0}},
            '{"video=800x600x32@0x1000,3200", -1, 1'b1,
              '{ST_OK, 16'd800, 16'd600, 8'd32, 16'd3200, 32'h0000_1000, 1'b1}},
            '{"vvideo=1x1x16@0x0,2",     -1, 1'b1,
              '{ST_OK, 16'd1, 16'd1, 8'd16, 16'd2, 32'h0, 1'b0}},
            '{"vidvideo=640x480x24@0xFD000000,1920", -1, 1'b0, '0},
            '{"video=1x99999x24@0x123abcDEF000,65535", -1, 1'b0, '0},
            '{"video=4x3x24@0xfedcb000,12zz", -1, 1'b0, '0},
            '{"video=1x1x16@0x0,2zz",    18, 1'b0, '0}
        };
        clear_parser();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[r]) begin
            line_bytes.delete();
            for (int i = 0; i < dir_rows[r].text.len(); i++) begin
                if (i == dir_rows[r].nul_pos) line_bytes.push_back(CH_NUL);
                line_bytes.push_back(dir_rows[r].text[i]);
            end
            send_line(dir_rows[r].has_exp, dir_rows[r].exp);
        end

        // Short lines against a held-off result side, so the output fills and full rises.
        hold_req = 1'b1;
        repeat (16) begin
            line_bytes.delete();
            line_bytes.push_back(8'($urandom_range(255)));
            send_line(1'b0, '0);
        end

        while (n_beats < MIN_BEATS || n_rand < MIN_LINES) begin
            case ((n_rand / 6) % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 73; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 73; end
                default: begin send_idle_pct = 13; recv_stall_pct = 13; end
            endcase
            build_random_line();
            send_line(1'b0, '0);
            n_rand++;
        end
        i_push <= 1'b0;

        wait (exp_modes.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d command lines in %0d byte beats; checked %0d results, %0d valid modes.",
                 n_lines, n_beats, n_checked, n_ok);
        $display("Status codes seen (bit per code, 7 down to 0): %b", status_seen);
        if (n_errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/vmap_pkg.sv
rtl/vmap_fifo.sv
rtl/vmap_front.sv
rtl/vmap_back.sv
rtl/video_mode_argument_parser.sv
dv/tb_video_mode_argument_parser.sv
